// ===== design/mts_pkg.sv =====
`timescale 1ns / 1ps
package mts_pkg;

   // operation codes
   localparam logic [1:0] FUNC_PUSH    = 2'd0;
   localparam logic [1:0] FUNC_DISCARD = 2'd1;
   localparam logic [1:0] FUNC_QUERY   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // fixed widths of the result fields
   localparam int MIN_VALUE_W = 32;
   localparam int DEPTH_NOW_W = 11;

   typedef logic [1:0] func_type;
   typedef logic [1:0] status_type;

endpackage

// ===== design/mts_ram.sv =====
`timescale 1ns / 1ps
module mts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/min_tracking_stack.sv =====
`timescale 1ns / 1ps
// Stack with running-minimum memory: at most one read and one write per transaction.
// The RAM is read as start is taken; the result is registered in ST_EXEC and strobes back in ST_IDLE.
// No new transaction is taken while busy (ST_EXEC), where the read-modify-write of
// the running-minimum RAM completes.
// Reset (synchronous, active high) empties the stack; the receiver cannot stall.
module min_tracking_stack #(
   parameter int DEPTH       = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  mts_pkg::func_type               req_func,
   input  logic [VALUE_WIDTH-1:0]          req_value,
   output logic                            rsp_valid,
   output mts_pkg::status_type             rsp_status,
   output logic [mts_pkg::MIN_VALUE_W-1:0] rsp_min_value,
   output logic [mts_pkg::DEPTH_NOW_W-1:0] rsp_depth_now
);

   import mts_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (VALUE_WIDTH > MIN_VALUE_W) ? VALUE_WIDTH : MIN_VALUE_W;
   localparam int DW = (CW > DEPTH_NOW_W) ? CW : DEPTH_NOW_W;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type              state_ff;
   logic [CW-1:0]          count_ff;
   func_type               func_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [VALUE_WIDTH-1:0] rsp_min_ff;

   logic [CW-1:0]          count_in;
   status_type             rsp_status_in;
   logic [VALUE_WIDTH-1:0] rsp_min_in;

   logic                   accept;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic                   empty;
   logic                   full;
   logic [MW-1:0]          min_wide;
   logic [DW-1:0]          depth_wide;

   assign busy    = (state_ff == ST_EXEC);
   assign accept  = start && !busy;
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));

   // read the top running minimum while the transaction is taken
   assign rd_en   = accept && !empty;
   assign rd_addr = AW'(count_ff - CW'(1));
   assign wr_addr = count_ff[AW-1:0];

   mts_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_min_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in      = count_ff;
      rsp_status_in = STATUS_DONE;
      rsp_min_in    = '0;
      wr_en         = 1'b0;
      wr_data       = value_ff;
      case (func_ff)
         FUNC_PUSH: begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               wr_en = (state_ff == ST_EXEC);
               if (!empty && rd_data < value_ff) begin
                  wr_data = rd_data;
               end
               count_in = count_ff + CW'(1);
            end
         end
         FUNC_DISCARD: begin
            if (empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         FUNC_QUERY: begin
            if (empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_min_in = rd_data;
            end
         end
         default: begin
            // unused code: answer done, hold state
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  func_ff  <= req_func;
                  value_ff <= req_value;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               count_ff      <= count_in;
               rsp_status_ff <= rsp_status_in;
               rsp_min_ff    <= rsp_min_in;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign min_wide      = MW'(rsp_min_ff);
   assign depth_wide    = DW'(count_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_min_value = min_wide[MIN_VALUE_W-1:0];
   assign rsp_depth_now = depth_wide[DEPTH_NOW_W-1:0];

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import mts_pkg::*;

   localparam int STACK_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 200000;
   localparam func_type FUNC_UNUSED = 2'd3;

   typedef struct packed {
      status_type               status;
      logic [MIN_VALUE_W-1:0]   min_value;
      logic [DEPTH_NOW_W-1:0]   depth_now;
   } stack_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   func_type               req_func;
   logic [31:0]            req_value;
   logic                   rsp_valid;
   status_type             rsp_status;
   logic [MIN_VALUE_W-1:0] rsp_min_value;
   logic [DEPTH_NOW_W-1:0] rsp_depth_now;

   // predicted stack: running minimum of entries 0..i, and the entry count
   logic [31:0]   running_min [STACK_DEPTH];
   int            held = 0;

   stack_result_type pending_results[$];
   stack_result_type oldest;
   bit            gaps_on = 1'b1;
   int            mismatches = 0;
   int            results_checked = 0;
   int            cycle_count = 0;
   int            pushes_done = 0;
   int            full_refusals = 0;
   int            empty_refusals = 0;
   int            queries_done = 0;
   int            unused_codes = 0;
   int            deepest = 0;

   min_tracking_stack #(
      .DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(32)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_min_value(rsp_min_value),
      .rsp_depth_now(rsp_depth_now)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("FAIL min_tracking_stack");
         $finish;
      end
   end

   function automatic stack_result_type apply_op(input func_type f, input logic [31:0] v);
      stack_result_type r;
      r.status = STATUS_DONE;
      r.min_value = '0;
      case (f)
         FUNC_PUSH: begin
            if (held == STACK_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               if (held != 0 && running_min[held-1] < v)
                  running_min[held] = running_min[held-1];
               else
                  running_min[held] = v;
               held++;
            end
         end
         FUNC_DISCARD: begin
            if (held == 0)
               r.status = STATUS_EMPTY;
            else
               held--;
         end
         FUNC_QUERY: begin
            if (held == 0)
               r.status = STATUS_EMPTY;
            else
               r.min_value = running_min[held-1];
         end
         default: begin
         end
      endcase
      r.depth_now = DEPTH_NOW_W'(held);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s expected %0h, got %0h", cycle_count, what,
                  want, got);
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction, depth_now", '0, 32'(rsp_depth_now));
         end else begin
            oldest = pending_results.pop_front();
            results_checked++;
            if (rsp_status !== oldest.status)
               report_mismatch("status", 32'(oldest.status), 32'(rsp_status));
            if (rsp_min_value !== oldest.min_value)
               report_mismatch("min_value", oldest.min_value, rsp_min_value);
            if (rsp_depth_now !== oldest.depth_now)
               report_mismatch("depth_now", 32'(oldest.depth_now), 32'(rsp_depth_now));
         end
      end
   end

   task automatic send_op(input func_type f, input logic [31:0] v);
      int gap;
      stack_result_type r;
      gap = 0;
      if (gaps_on && $urandom_range(0, 99) < 18)
         gap = $urandom_range(1, 5);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      r = apply_op(f, v);
      pending_results.push_back(r);
      if (held > deepest)
         deepest = held;
      case (r.status)
         STATUS_FULL:  full_refusals++;
         STATUS_EMPTY: empty_refusals++;
         default: begin
            if (f == FUNC_PUSH)
               pushes_done++;
            else if (f == FUNC_QUERY)
               queries_done++;
            else if (f == FUNC_UNUSED)
               unused_codes++;
         end
      endcase
   endtask

   function automatic logic [31:0] draw_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 32'($urandom_range(0, 15));
         3: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   // values above a floor that drops as the stack grows (one in eight drawn freely), so the minimum moves
   function automatic logic [31:0] fill_value();
      logic [31:0] base;
      if ($urandom_range(0, 7) == 0)
         return draw_value();
      base = 32'(STACK_DEPTH - 1 - held);
      return (base << 22) | 32'($urandom_range(0, 32'h3F_FFFF));
   endfunction

   function automatic func_type pick_func(input int push_pct, input int discard_pct,
                                          input int query_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_pct)
         return FUNC_PUSH;
      if (r < push_pct + discard_pct)
         return FUNC_DISCARD;
      if (r < push_pct + discard_pct + query_pct)
         return FUNC_QUERY;
      return FUNC_UNUSED;
   endfunction

   task automatic test_empty_stack();
      send_op(FUNC_DISCARD, '1);
      send_op(FUNC_QUERY, '1);
      send_op(FUNC_UNUSED, '1);
      send_op(FUNC_UNUSED, '0);
   endtask

   task automatic test_basic_ops();
      send_op(FUNC_PUSH, 32'hFFFF_FFFF);
      send_op(FUNC_QUERY, '0);
      send_op(FUNC_PUSH, 32'h0000_0000);
      send_op(FUNC_QUERY, '0);
      send_op(FUNC_PUSH, 32'h0000_0005);
      send_op(FUNC_QUERY, 32'hA5A5_5A5A);
      send_op(FUNC_DISCARD, '0);
      send_op(FUNC_DISCARD, '0);
      send_op(FUNC_QUERY, '0);
      send_op(FUNC_PUSH, 32'h8000_0000);
      send_op(FUNC_PUSH, 32'h8000_0001);
      send_op(FUNC_QUERY, '0);
      send_op(FUNC_UNUSED, 32'h5A5A_A5A5);
      send_op(FUNC_DISCARD, '0);
      send_op(FUNC_DISCARD, '0);
      send_op(FUNC_QUERY, '0);
      send_op(FUNC_DISCARD, '0);
      send_op(FUNC_QUERY, '0);
      send_op(FUNC_DISCARD, '0);
   endtask

   // balanced push and discard keep the stack shallow and hit empty often
   task automatic test_shallow_mix();
      repeat (220) send_op(pick_func(40, 40, 17), draw_value());
   endtask

   task automatic test_fill_to_full();
      int sent;
      sent = 0;
      gaps_on = 1'b0;
      while (held < STACK_DEPTH) begin
         if (sent == 400)
            gaps_on = 1'b1;
         send_op(pick_func(85, 5, 9), fill_value());
         sent++;
      end
   endtask

   task automatic test_at_full();
      repeat (3) send_op(FUNC_PUSH, draw_value());
      repeat (70) send_op(pick_func(45, 20, 30), draw_value());
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_PUSH;
      req_value = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_basic_ops();
      test_shallow_mix();
      test_fill_to_full();
      test_at_full();

      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d transactions: %0d pushes, %0d queries, %0d unused codes",
               results_checked, pushes_done, queries_done, unused_codes);
      $display("refused %0d on empty and %0d on full, deepest %0d, %0d mismatches",
               empty_refusals, full_refusals, deepest, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASS min_tracking_stack");
      end else begin
         $display("FAIL min_tracking_stack");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/mts_pkg.sv
design/mts_ram.sv
design/min_tracking_stack.sv
test/testbench.sv
